/* hdl/obfv_pkg.sv */
// Shared types, constants and width helpers for the orthonormal basis pipeline.
// No dependencies; every other file of the block imports this package.
package obfv_pkg;

    localparam int FRAC_BITS_DEF = 14;    // default fraction bits of the Q format
    localparam int DATA_W        = 16;    // width of every vector component
    localparam int MAG_BITS      = 16;    // result bits of the reciprocal root search
    localparam int SUM_W         = 32;    // sum of two squares, at most 2^31
    localparam int SQ_W          = 31;    // one square, at most 2^30
    localparam int PROD_W        = 49;    // running (2m-1)*s, magnitude below 2^47
    localparam int CROSS_W       = 33;    // difference of two 16x16 products

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    // Per item context that travels alongside the root search.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     sel;     // |x| > |y|: second axis is (-z, 0, x)
        logic                     degen;   // input is the zero vector
        logic                     neg0;    // first numerator is negative
        logic                     neg1;    // second numerator is negative
        logic [SUM_W-1:0]         s;       // sum of squares
    } ctx_t;

    // Width of the signed remainder of the root search. It holds the scaled
    // square c^2 * 4^(FRAC_BITS+1) as well as any trial term below 2^63.
    function automatic int rem_width(input int frac_bits);
        int cw;
        begin
            cw = 2 * frac_bits + 33;
            return ((cw > 63) ? cw : 63) + 2;
        end
    endfunction

endpackage

/* hdl/obfv_front.sv */
// Front end of the basis pipeline: axis choice, squares, their sum and the
// start values of the reciprocal root search. Depends on obfv_pkg.
module obfv_front import obfv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RW = rem_width(FRAC_BITS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] in_x,
    input  logic signed [DATA_W-1:0] in_y,
    input  logic signed [DATA_W-1:0] in_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ctx_t                     out_ctx,
    output logic [1:0][MAG_BITS-1:0] out_m,
    output logic [1:0][RW-1:0]       out_r,
    output logic [1:0][PROD_W-1:0]   out_p
);

    localparam int C_SHIFT = 2 * FRAC_BITS + 2;

    logic [DATA_W:0]          ax;
    logic [DATA_W:0]          ay;
    logic                     sel;
    logic signed [DATA_W-1:0] pick;
    logic signed [31:0]       sq_pick;
    logic signed [31:0]       sq_z;
    ctx_t                     st0_ctx_next;
    logic                     st0_valid_reg;
    ctx_t                     st0_ctx_reg;
    logic [SQ_W-1:0]          st0_sqa_reg;
    logic [SQ_W-1:0]          st0_sqz_reg;
    logic                     st0_ready;
    logic [SUM_W-1:0]         s_sum;
    ctx_t                     st1_ctx_next;
    logic [RW-1:0]            r0_next;
    logic [RW-1:0]            r1_next;
    logic [PROD_W-1:0]        p_next;
    logic                     st1_valid_reg;
    ctx_t                     st1_ctx_reg;
    logic [1:0][RW-1:0]       st1_r_reg;
    logic [1:0][PROD_W-1:0]   st1_p_reg;
    logic                     st1_ready;

    // Magnitudes one bit wider so that the most negative value is exact.
    assign ax = in_x[DATA_W-1] ? (~{1'b1, in_x} + 17'd1) : {1'b0, in_x};
    assign ay = in_y[DATA_W-1] ? (~{1'b1, in_y} + 17'd1) : {1'b0, in_y};
    assign sel  = ax > ay;
    assign pick = sel ? in_x : in_y;
    assign sq_pick = pick * pick;
    assign sq_z    = in_z * in_z;

    always_comb begin
        st0_ctx_next.x     = in_x;
        st0_ctx_next.y     = in_y;
        st0_ctx_next.z     = in_z;
        st0_ctx_next.sel   = sel;
        st0_ctx_next.degen = (in_x == '0) && (in_y == '0) && (in_z == '0);
        // The first numerator is -z or z, the second x or -y.
        st0_ctx_next.neg0  = sel ? (!in_z[DATA_W-1] && (in_z != '0)) : in_z[DATA_W-1];
        st0_ctx_next.neg1  = sel ? in_x[DATA_W-1] : (!in_y[DATA_W-1] && (in_y != '0));
        st0_ctx_next.s     = '0;
    end

    assign st1_ready = !st1_valid_reg || out_ready;
    assign st0_ready = !st0_valid_reg || st1_ready;
    assign in_ready  = st0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (st0_ready) begin
            st0_valid_reg <= in_valid;
        end
        if (st0_ready && in_valid) begin
            st0_ctx_reg <= st0_ctx_next;
            st0_sqa_reg <= sq_pick[SQ_W-1:0];
            st0_sqz_reg <= sq_z[SQ_W-1:0];
        end
    end

    // The search keeps r = c^2 * 4^(F+1) - (2m-1)^2 * s and p = (2m-1) * s,
    // starting from m = 0.
    assign s_sum   = SUM_W'(st0_sqa_reg) + SUM_W'(st0_sqz_reg);
    assign r0_next = (RW'(st0_sqz_reg) << C_SHIFT) - RW'(s_sum);
    assign r1_next = (RW'(st0_sqa_reg) << C_SHIFT) - RW'(s_sum);
    assign p_next  = PROD_W'(0) - PROD_W'(s_sum);

    always_comb begin
        st1_ctx_next   = st0_ctx_reg;
        st1_ctx_next.s = s_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_ready) begin
            st1_valid_reg <= st0_valid_reg;
        end
        if (st1_ready && st0_valid_reg) begin
            st1_ctx_reg  <= st1_ctx_next;
            st1_r_reg[0] <= r0_next;
            st1_r_reg[1] <= r1_next;
            st1_p_reg[0] <= p_next;
            st1_p_reg[1] <= p_next;
        end
    end

    assign out_valid = st1_valid_reg;
    assign out_ctx   = st1_ctx_reg;
    assign out_m     = '0;
    assign out_r     = st1_r_reg;
    assign out_p     = st1_p_reg;

endmodule

/* hdl/obfv_iter.sv */
// One stage of the reciprocal square root search: decides one result bit
// for both unit components of the second axis. Depends on obfv_pkg.
module obfv_iter import obfv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT_IDX   = MAG_BITS - 1,
    localparam int RW = rem_width(FRAC_BITS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ctx_t                     in_ctx,
    input  logic [1:0][MAG_BITS-1:0] in_m,
    input  logic [1:0][RW-1:0]       in_r,
    input  logic [1:0][PROD_W-1:0]   in_p,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ctx_t                     out_ctx,
    output logic [1:0][MAG_BITS-1:0] out_m,
    output logic [1:0][RW-1:0]       out_r,
    output logic [1:0][PROD_W-1:0]   out_p
);

    localparam logic [MAG_BITS-1:0] BIT_MASK = MAG_BITS'(1) << BIT_IDX;

    logic                     valid_reg;
    ctx_t                     ctx_reg;
    logic [1:0][MAG_BITS-1:0] m_reg;
    logic [1:0][RW-1:0]       r_reg;
    logic [1:0][PROD_W-1:0]   p_reg;
    logic [1:0][MAG_BITS-1:0] m_next;
    logic [1:0][RW-1:0]       r_next;
    logic [1:0][PROD_W-1:0]   p_next;
    logic [RW-1:0]            s_ext;
    logic [PROD_W-1:0]        s_step;

    assign s_ext  = RW'(in_ctx.s);
    assign s_step = PROD_W'(in_ctx.s) << (BIT_IDX + 1);

    for (genvar j = 0; j < 2; j++) begin : g_comp
        logic [RW-1:0] p_ext;
        logic [RW-1:0] delta;
        logic [RW-1:0] trial;
        logic          take;

        // Raising 2m-1 by 2*bit grows (2m-1)^2 * s by 4*bit*p + 4*bit^2*s.
        // Once m has reached its ceiling of 2^15 no further bit is set.
        assign p_ext = {{(RW - PROD_W){in_p[j][PROD_W-1]}}, in_p[j]};
        assign delta = (p_ext << (BIT_IDX + 2)) + (s_ext << (2 * BIT_IDX + 2));
        assign trial = in_r[j] - delta;
        assign take  = !in_m[j][MAG_BITS-1] && !trial[RW-1];

        assign m_next[j] = take ? (in_m[j] | BIT_MASK) : in_m[j];
        assign r_next[j] = take ? trial : in_r[j];
        assign p_next[j] = take ? (in_p[j] + s_step) : in_p[j];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ctx_reg <= in_ctx;
            m_reg   <= m_next;
            r_reg   <= r_next;
            p_reg   <= p_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_m     = m_reg;
    assign out_r     = r_reg;
    assign out_p     = p_reg;

endmodule

/* hdl/obfv_cross.sv */
// Back end of the basis pipeline: signs and saturation of the second axis,
// the cross product and its rounding to Q format. Depends on obfv_pkg.
module obfv_cross import obfv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ctx_t                     in_ctx,
    input  logic [1:0][MAG_BITS-1:0] in_m,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_b2_x,
    output logic signed [DATA_W-1:0] out_b2_y,
    output logic signed [DATA_W-1:0] out_b2_z,
    output logic signed [DATA_W-1:0] out_b3_x,
    output logic signed [DATA_W-1:0] out_b3_y,
    output logic signed [DATA_W-1:0] out_b3_z,
    output logic                     out_degen
);

    localparam int RND_W = CROSS_W + 1;
    localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(SAT_MAX);
    localparam logic signed [RND_W-1:0] RND_MIN  = {{(RND_W - DATA_W){1'b1}}, SAT_MIN};

    logic [1:0][DATA_W-1:0]   unit;
    logic                     fa_valid_reg;
    ctx_t                     fa_ctx_reg;
    logic signed [DATA_W-1:0] fa_a_reg;
    logic signed [DATA_W-1:0] fa_b_reg;
    logic signed [DATA_W-1:0] fa_c_reg;
    logic                     fa_ready;
    logic signed [31:0]       yc;
    logic signed [31:0]       zb;
    logic signed [31:0]       za;
    logic signed [31:0]       xc;
    logic signed [31:0]       xb;
    logic signed [31:0]       ya;
    logic                     fb_valid_reg;
    logic                     fb_degen_reg;
    logic signed [DATA_W-1:0] fb_a_reg;
    logic signed [DATA_W-1:0] fb_b_reg;
    logic signed [DATA_W-1:0] fb_c_reg;
    logic [2:0][CROSS_W-1:0]  fb_e_reg;
    logic                     fb_ready;
    logic [2:0][DATA_W-1:0]   rounded;
    logic                     fc_valid_reg;
    logic                     fc_degen_reg;
    logic [2:0][DATA_W-1:0]   fc_b2_reg;
    logic [2:0][DATA_W-1:0]   fc_b3_reg;

    // A negative numerator takes the search result as it is (down to -2^15);
    // a positive one is limited to the largest positive code.
    for (genvar j = 0; j < 2; j++) begin : g_unit
        logic neg;
        assign neg = (j == 0) ? in_ctx.neg0 : in_ctx.neg1;
        assign unit[j] = neg ? (~in_m[j] + MAG_BITS'(1))
                       : (in_m[j][MAG_BITS-1] ? SAT_MAX : in_m[j]);
    end

    assign fb_ready = !fb_valid_reg || (!fc_valid_reg || out_ready);
    assign fa_ready = !fa_valid_reg || fb_ready;
    assign in_ready = fa_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fa_valid_reg <= 1'b0;
        end else if (fa_ready) begin
            fa_valid_reg <= in_valid;
        end
        if (fa_ready && in_valid) begin
            fa_ctx_reg <= in_ctx;
            fa_a_reg   <= in_ctx.sel ? unit[0] : '0;
            fa_b_reg   <= in_ctx.sel ? '0 : unit[0];
            fa_c_reg   <= unit[1];
        end
    end

    assign yc = fa_ctx_reg.y * fa_c_reg;
    assign zb = fa_ctx_reg.z * fa_b_reg;
    assign za = fa_ctx_reg.z * fa_a_reg;
    assign xc = fa_ctx_reg.x * fa_c_reg;
    assign xb = fa_ctx_reg.x * fa_b_reg;
    assign ya = fa_ctx_reg.y * fa_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_valid_reg <= 1'b0;
        end else if (fb_ready) begin
            fb_valid_reg <= fa_valid_reg;
        end
        if (fb_ready && fa_valid_reg) begin
            fb_degen_reg <= fa_ctx_reg.degen;
            fb_a_reg     <= fa_a_reg;
            fb_b_reg     <= fa_b_reg;
            fb_c_reg     <= fa_c_reg;
            fb_e_reg[0]  <= {yc[31], yc} - {zb[31], zb};
            fb_e_reg[1]  <= {za[31], za} - {xc[31], xc};
            fb_e_reg[2]  <= {xb[31], xb} - {ya[31], ya};
        end
    end

    // Scale by 2^-F rounding half up, then saturate to the component range.
    for (genvar k = 0; k < 3; k++) begin : g_round
        logic signed [RND_W-1:0] biased;
        logic signed [RND_W-1:0] shifted;
        assign biased  = $signed({fb_e_reg[k][CROSS_W-1], fb_e_reg[k]}) + HALF_LSB;
        assign shifted = biased >>> FRAC_BITS;
        assign rounded[k] = (shifted > RND_MAX) ? SAT_MAX
                          : ((shifted < RND_MIN) ? SAT_MIN : shifted[DATA_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_valid_reg <= 1'b0;
        end else if (!fc_valid_reg || out_ready) begin
            fc_valid_reg <= fb_valid_reg;
        end
        if ((!fc_valid_reg || out_ready) && fb_valid_reg) begin
            fc_degen_reg <= fb_degen_reg;
            fc_b2_reg[0] <= fb_degen_reg ? '0 : fb_a_reg;
            fc_b2_reg[1] <= fb_degen_reg ? '0 : fb_b_reg;
            fc_b2_reg[2] <= fb_degen_reg ? '0 : fb_c_reg;
            fc_b3_reg    <= fb_degen_reg ? '0 : rounded;
        end
    end

    assign out_valid = fc_valid_reg;
    assign out_degen = fc_degen_reg;
    assign out_b2_x  = fc_b2_reg[0];
    assign out_b2_y  = fc_b2_reg[1];
    assign out_b2_z  = fc_b2_reg[2];
    assign out_b3_x  = fc_b3_reg[0];
    assign out_b3_y  = fc_b3_reg[1];
    assign out_b3_z  = fc_b3_reg[2];

endmodule

/* hdl/orthonormal_basis_from_vector.sv */
// Top level of the orthonormal basis pipeline: front end, root search stages
// and cross product back end. Depends on obfv_pkg, obfv_front, obfv_iter, obfv_cross.
//
// This block takes one signed Q2.14 vector v per transfer and returns the two
// further axes of a coordinate system built on it. When |x| > |y| the second
// axis is (-z, 0, x) / sqrt(x*x + z*z), otherwise (0, z, -y) / sqrt(y*y + z*z);
// each unit component is the exact quotient rounded to nearest with ties away
// from zero, and a positive component that does not fit in 16 bits (which only
// happens when FRAC_BITS leaves no room for 1.0) is held at the largest positive
// code. The third axis is v crossed with the rounded second
// axis, scaled back to Q format rounding half up and saturated to 16 bits. A
// zero input sets the degenerate flag and returns zero vectors. The pipeline
// takes one transfer in every clock cycle while the output is not stalled
// and passes it through 21 register stages: two front stages
// form the squares, their sum and the
// start of the search, sixteen stages each settle one bit of both unit
// components with a shift, add and compare on the remainder, and three back
// stages apply signs, form the six cross products and round them. Every stage
// carries its own valid bit and takes new data when it is empty or its successor
// moves on, so a stalled output fills the empty stages behind it and nothing
// is dropped or duplicated. s_ready is high whenever the output register is empty
// or being read in that cycle. FRAC_BITS sets the fraction bits of every field;
// the remainder datapath of the search widens with it.
module orthonormal_basis_from_vector import obfv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_in_x,
    input  logic signed [DATA_W-1:0] s_in_y,
    input  logic signed [DATA_W-1:0] s_in_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_basis2_x,
    output logic signed [DATA_W-1:0] m_basis2_y,
    output logic signed [DATA_W-1:0] m_basis2_z,
    output logic signed [DATA_W-1:0] m_basis3_x,
    output logic signed [DATA_W-1:0] m_basis3_y,
    output logic signed [DATA_W-1:0] m_basis3_z,
    output logic                     m_degenerate
);

    localparam int RW = rem_width(FRAC_BITS);

    // Element i of each chain is the output of the stage before search stage i;
    // the last element feeds the back end.
    logic                     valid_chain [MAG_BITS+1];
    logic                     ready_chain [MAG_BITS+1];
    ctx_t                     ctx_chain   [MAG_BITS+1];
    logic [1:0][MAG_BITS-1:0] m_chain     [MAG_BITS+1];
    logic [1:0][RW-1:0]       r_chain     [MAG_BITS+1];
    logic [1:0][PROD_W-1:0]   p_chain     [MAG_BITS+1];

    obfv_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (s_in_x),
        .in_y      (s_in_y),
        .in_z      (s_in_z),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_ctx   (ctx_chain[0]),
        .out_m     (m_chain[0]),
        .out_r     (r_chain[0]),
        .out_p     (p_chain[0])
    );

    // Search stage i settles bit 15 - i of both unit components.
    for (genvar i = 0; i < MAG_BITS; i++) begin : g_search
        obfv_iter #(
            .FRAC_BITS (FRAC_BITS),
            .BIT_IDX   (MAG_BITS - 1 - i)
        ) u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_ctx    (ctx_chain[i]),
            .in_m      (m_chain[i]),
            .in_r      (r_chain[i]),
            .in_p      (p_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_ctx   (ctx_chain[i+1]),
            .out_m     (m_chain[i+1]),
            .out_r     (r_chain[i+1]),
            .out_p     (p_chain[i+1])
        );
    end

    // The final remainder and running product are not needed by the back end.
    obfv_cross #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_chain[MAG_BITS]),
        .in_ready  (ready_chain[MAG_BITS]),
        .in_ctx    (ctx_chain[MAG_BITS]),
        .in_m      (m_chain[MAG_BITS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_b2_x  (m_basis2_x),
        .out_b2_y  (m_basis2_y),
        .out_b2_z  (m_basis2_z),
        .out_b3_x  (m_basis3_x),
        .out_b3_y  (m_basis3_y),
        .out_b3_z  (m_basis3_z),
        .out_degen (m_degenerate)
    );

endmodule

/* hdl/obfv_checker.sv */
// Port level checks for orthonormal_basis_from_vector, attached by bind.
// Depends on obfv_pkg and on the top level's port list.
module obfv_checker import obfv_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [DATA_W-1:0] s_in_x,
    input logic signed [DATA_W-1:0] s_in_y,
    input logic signed [DATA_W-1:0] s_in_z,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_basis2_x,
    input logic signed [DATA_W-1:0] m_basis2_y,
    input logic signed [DATA_W-1:0] m_basis2_z,
    input logic signed [DATA_W-1:0] m_basis3_x,
    input logic signed [DATA_W-1:0] m_basis3_y,
    input logic signed [DATA_W-1:0] m_basis3_z,
    input logic                     m_degenerate
);

    // A result that is offered but not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_basis2_x) && $stable(m_basis2_y)
            && $stable(m_basis2_z) && $stable(m_basis3_x) && $stable(m_basis3_y)
            && $stable(m_basis3_z) && $stable(m_degenerate))
        else $error("result changed while stalled");

    // An empty or draining output stage lets the whole pipeline move.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled although output is free");

    // A zero input yields zero vectors.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_basis2_x == '0) && (m_basis2_y == '0)
            && (m_basis2_z == '0) && (m_basis3_x == '0) && (m_basis3_y == '0)
            && (m_basis3_z == '0))
        else $error("degenerate result with nonzero vector");

    // Either branch leaves the x or the y component of the second axis at zero.
    a_axis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_basis2_x == '0) || (m_basis2_y == '0))
        else $error("second axis has no zero component");

endmodule

bind orthonormal_basis_from_vector obfv_checker u_obfv_checker (.*);
